FILE: rtl/hsvrgb_pkg.sv
`timescale 1ns / 1ps

package hsvrgb_pkg;

	// fixed-point format of hue, saturation and value
	localparam int FRAC_BITS = 16;
	localparam int IN_W      = 17;
	localparam int ONE       = 1 << FRAC_BITS;

	// hue * 6 and its integer part (sector before wrap)
	localparam int H6_W      = IN_W + 3;
	localparam int SEC_RAW_W = H6_W - FRAC_BITS;
	localparam int SECTORS   = 6;

	// 1 - f, then the signed factors 1-s, 1-s*f, 1-s*(1-f)
	localparam int OMF_W = FRAC_BITS + 1;
	localparam int FAC_W = IN_W + 2;

	// channel level v*factor, signed, 2*FRAC_BITS fraction bits
	localparam int LVL_W = IN_W + 1 + FAC_W;

	localparam int OUT_W    = 8;
	localparam int CHAN_MAX = 255;

	localparam int PIPE_DEPTH = 5;
	localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

	localparam int S_DATA_W = ((3 * IN_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((3 * OUT_W + 7) / 8) * 8;

	typedef logic [IN_W-1:0]         fld_t;
	typedef logic signed [FAC_W-1:0] factor_t;
	typedef logic signed [LVL_W-1:0] level_t;
	typedef logic [OUT_W-1:0]        chan_t;

	// color wheel sectors, red at 0
	typedef enum logic [2:0] {
		SEC_RED_YEL,
		SEC_YEL_GRN,
		SEC_GRN_CYN,
		SEC_CYN_BLU,
		SEC_BLU_MAG,
		SEC_MAG_RED
	} sector_t;

	// integer part of hue*6 stays below twice the sector count
	function automatic sector_t wrap_sector(input logic [SEC_RAW_W-1:0] raw);
		logic [SEC_RAW_W-1:0] r;
		r = (raw >= SEC_RAW_W'(SECTORS)) ? raw - SEC_RAW_W'(SECTORS) : raw;
		return sector_t'(r[2:0]);
	endfunction

endpackage

FILE: rtl/hsvrgb_to_byte.sv
`timescale 1ns / 1ps

module hsvrgb_to_byte (
	input  hsvrgb_pkg::level_t level,
	output hsvrgb_pkg::chan_t  chan
);
	import hsvrgb_pkg::*;

	localparam int MAG_W  = LVL_W - 1;
	localparam int PROD_W = MAG_W + OUT_W;
	localparam int HI_W   = PROD_W - 2 * FRAC_BITS;

	logic [MAG_W-1:0]  mag;
	logic [PROD_W-1:0] prod;
	logic [HI_W-1:0]   hi;

	// level * 255 as (level << 8) - level
	assign mag  = level[MAG_W-1:0];
	assign prod = (PROD_W'(mag) << OUT_W) - PROD_W'(mag);
	assign hi   = prod[PROD_W-1:2*FRAC_BITS];

	always_comb begin
		if (level <= 0) begin
			chan = '0;
		end else if (hi > HI_W'(CHAN_MAX)) begin
			chan = OUT_W'(CHAN_MAX);
		end else begin
			chan = hi[OUT_W-1:0];
		end
	end

endmodule

FILE: rtl/hsv_to_rgb_color_core.sv
`timescale 1ns / 1ps
// channel  dir  handshake           tdata fields (lsb up)
// s_axis   in   s_tvalid/s_tready   hue[16:0] saturation[33:17] brightness[50:34]
// m_axis   out  m_tvalid/m_tready   red[7:0] green[15:8] blue[23:16]
//
// Five register stages, one pixel per clock while the output is not stalled.
// Stages: hue*6 and sector, s*f products, factors, v*factor, route and byte clamp.
// Each stage loads when it is empty or the next one moves, so bubbles close
// up under stall and s_tready drops only with all five stages full.
// arst_n clears the valid bits only.

module hsv_to_rgb_color_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [hsvrgb_pkg::S_DATA_W-1:0] s_tdata,  // hue, saturation, brightness
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [hsvrgb_pkg::M_DATA_W-1:0] m_tdata   // red, green, blue
);
	import hsvrgb_pkg::*;

	fld_t hue, sat, bri;
	assign hue = s_tdata[IN_W-1:0];
	assign sat = s_tdata[2*IN_W-1:IN_W];
	assign bri = s_tdata[3*IN_W-1:2*IN_W];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en1, en2, en3, en4, en5;

	assign en5 = !vld_s5 || m_tready;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= s_tvalid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
		end
	end

	// stage 1: hue * 6 split into sector and fraction
	logic [H6_W-1:0]      h6;
	logic [FRAC_BITS-1:0] f_s1;
	sector_t              sec_s1;
	fld_t                 sat_s1, bri_s1;
	logic                 grey_s1;

	assign h6 = (H6_W'(hue) << 2) + (H6_W'(hue) << 1);

	always_ff @(posedge clk) begin
		if (en1) begin
			sec_s1  <= wrap_sector(h6[H6_W-1:FRAC_BITS]);
			f_s1    <= h6[FRAC_BITS-1:0];
			sat_s1  <= sat;
			bri_s1  <= bri;
			grey_s1 <= (sat == '0);
		end
	end

	// stage 2: s*f and s*(1-f), truncated to FRAC_BITS fraction bits
	logic [IN_W+FRAC_BITS-1:0] sf_full;
	logic [OMF_W-1:0]          omf;
	logic [IN_W+OMF_W-1:0]     s1f_full;
	fld_t                      sf_s2, sat_s2, bri_s2;
	logic [IN_W:0]             s1f_s2;
	sector_t                   sec_s2;
	logic                      grey_s2;

	assign sf_full  = (IN_W+FRAC_BITS)'(sat_s1) * (IN_W+FRAC_BITS)'(f_s1);
	assign omf      = OMF_W'(ONE) - OMF_W'(f_s1);
	assign s1f_full = (IN_W+OMF_W)'(sat_s1) * (IN_W+OMF_W)'(omf);

	always_ff @(posedge clk) begin
		if (en2) begin
			sf_s2   <= sf_full[IN_W+FRAC_BITS-1:FRAC_BITS];
			s1f_s2  <= s1f_full[IN_W+OMF_W-1:FRAC_BITS];
			sat_s2  <= sat_s1;
			bri_s2  <= bri_s1;
			sec_s2  <= sec_s1;
			grey_s2 <= grey_s1;
		end
	end

	// stage 3: signed factors, which can go negative only once saturation exceeds one
	factor_t fp_s3, fq_s3, ft_s3;
	fld_t    bri_s3;
	sector_t sec_s3;
	logic    grey_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			fp_s3   <= $signed(FAC_W'(ONE)) - $signed(FAC_W'(sat_s2));
			fq_s3   <= $signed(FAC_W'(ONE)) - $signed(FAC_W'(sf_s2));
			ft_s3   <= $signed(FAC_W'(ONE)) - $signed(FAC_W'(s1f_s2));
			bri_s3  <= bri_s2;
			sec_s3  <= sec_s2;
			grey_s3 <= grey_s2;
		end
	end

	// stage 4: channel levels v * factor
	logic signed [IN_W:0] bri_sx;
	level_t  lp_s4, lq_s4, lt_s4;
	fld_t    bri_s4;
	sector_t sec_s4;
	logic    grey_s4;

	assign bri_sx = $signed({1'b0, bri_s3});

	always_ff @(posedge clk) begin
		if (en4) begin
			lp_s4   <= bri_sx * fp_s3;
			lq_s4   <= bri_sx * fq_s3;
			lt_s4   <= bri_sx * ft_s3;
			bri_s4  <= bri_s3;
			sec_s4  <= sec_s3;
			grey_s4 <= grey_s3;
		end
	end

	// stage 5: route by sector (all channels v when grey), scale to a byte
	level_t lv, lr, lg, lb;
	chan_t  r_c, g_c, b_c;
	chan_t  red_s5, green_s5, blue_s5;

	assign lv = level_t'({bri_s4, FRAC_BITS'(0)});

	always_comb begin
		if (grey_s4) begin
			lr = lv; lg = lv; lb = lv;
		end else begin
			case (sec_s4)
				SEC_RED_YEL: begin lr = lv;    lg = lt_s4; lb = lp_s4; end
				SEC_YEL_GRN: begin lr = lq_s4; lg = lv;    lb = lp_s4; end
				SEC_GRN_CYN: begin lr = lp_s4; lg = lv;    lb = lt_s4; end
				SEC_CYN_BLU: begin lr = lp_s4; lg = lq_s4; lb = lv;    end
				SEC_BLU_MAG: begin lr = lt_s4; lg = lp_s4; lb = lv;    end
				default:     begin lr = lv;    lg = lp_s4; lb = lq_s4; end
			endcase
		end
	end

	hsvrgb_to_byte u_red   (.level(lr), .chan(r_c));
	hsvrgb_to_byte u_green (.level(lg), .chan(g_c));
	hsvrgb_to_byte u_blue  (.level(lb), .chan(b_c));

	always_ff @(posedge clk) begin
		if (en5) begin
			red_s5   <= r_c;
			green_s5 <= g_c;
			blue_s5  <= b_c;
		end
	end

	assign m_tvalid = vld_s5;
	assign m_tdata  = M_DATA_W'({blue_s5, green_s5, red_s5});

endmodule

FILE: rtl/hsvrgb_checker.sv
`timescale 1ns / 1ps

module hsvrgb_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [hsvrgb_pkg::M_DATA_W-1:0] m_tdata
);
	import hsvrgb_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic             s_xfer, m_xfer;

	assign s_xfer = s_tvalid && s_tready;
	assign m_xfer = m_tvalid && m_tready;

	// transactions in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CNT_W'(s_xfer) - CNT_W'(m_xfer);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(PIPE_DEPTH))
		else $error("more transactions in flight than stages");

	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> !m_tvalid)
		else $error("result without a pending input");

	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(PIPE_DEPTH) |-> s_tready)
		else $error("input stalled with a free stage");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while output drains");

endmodule

bind hsv_to_rgb_color_core hsvrgb_checker u_hsvrgb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
